### hdl/rcppm_pkg.sv
// Shared constants and types of the RC PPM frame generator.
// Used by the register block, the timing core and the top level.
package rcppm_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [CNT_W-1:0] FRAME_LEN_RST  = 16'd22500;
    localparam logic [CNT_W-1:0] PULSE_LEN_RST  = 16'd300;
    localparam logic             ACTIVE_RST     = 1'b1;
    localparam logic [CNT_W-1:0] FIRST_SLOT_RST = 16'd1000;
    localparam logic [CNT_W-1:0] OTHER_SLOT_RST = 16'd1500;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [1:0] REG_PULSE_LENGTH = 2'd1;
    localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] frame_length;
        logic [CNT_W-1:0] pulse_length;
        logic             active_level;
    } t_cfg;

    typedef struct packed {
        logic              pin_level;
        logic              frame_running;
        logic [SLOT_W-1:0] slot_index;
    } t_result;

endpackage

### hdl/rcppm_apb_regs.sv
// Configuration registers of the RC PPM frame generator behind an APB-style port.
// Depends on rcppm_pkg for register codes, reset values and the t_cfg type.
module rcppm_apb_regs
    import rcppm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length <= FRAME_LEN_RST;
            r_cfg.pulse_length <= PULSE_LEN_RST;
            r_cfg.active_level <= ACTIVE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_FRAME_LENGTH: r_cfg.frame_length <= pwdata[CNT_W-1:0];
                REG_PULSE_LENGTH: r_cfg.pulse_length <= pwdata[CNT_W-1:0];
                REG_ACTIVE_LEVEL: r_cfg.active_level <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_FRAME_LENGTH: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_cfg.frame_length};
            REG_PULSE_LENGTH: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_cfg.pulse_length};
            REG_ACTIVE_LEVEL: prdata = {{(APB_DATA_W-1){1'b0}}, r_cfg.active_level};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/rcppm_core.sv
// Timing state of the PPM generator: slot widths, elapsed counters and pulse control.
// Depends on rcppm_pkg; one request is applied per cycle when i_fire is high.
module rcppm_core
    import rcppm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_fire,
    input  logic              i_kind,
    input  logic [SLOT_W-1:0] i_channel,
    input  logic [CNT_W-1:0]  i_slot_width,
    output t_result           o_result
);

    logic [CNT_W-1:0]  r_widths [CHANNELS];
    logic [CNT_W-1:0]  r_since_frame, n_since_frame;
    logic [CNT_W-1:0]  r_since_slot,  n_since_slot;
    logic [CNT_W-1:0]  r_since_pulse, n_since_pulse;
    logic              r_running,      n_running;
    logic              r_pulse_wanted, n_pulse_wanted;
    logic              r_pulse_idle,   n_pulse_idle;
    logic              r_slot_begin,   n_slot_begin;
    logic [SLOT_W-1:0] r_slot_counter, n_slot_counter;
    logic              r_pin,          n_pin;

    logic              w_frame_done;
    logic [SLOT_W-1:0] w_slot_sel;
    logic [CNT_W-1:0]  w_cur_width;
    logic              w_wr_ok;

    assign w_frame_done = (r_slot_counter >= SLOT_W'(CHANNELS));
    assign w_slot_sel   = w_frame_done ? '0 : r_slot_counter;
    assign w_cur_width  = r_widths[w_slot_sel[CH_IDX_W-1:0]];
    assign w_wr_ok      = i_fire && (i_kind == KIND_WRITE)
                          && (i_channel < SLOT_W'(CHANNELS));

    always_comb begin
        n_since_frame  = r_since_frame;
        n_since_slot   = r_since_slot;
        n_since_pulse  = r_since_pulse;
        n_running      = r_running;
        n_pulse_wanted = r_pulse_wanted;
        n_pulse_idle   = r_pulse_idle;
        n_slot_begin   = r_slot_begin;
        n_slot_counter = r_slot_counter;
        n_pin          = r_pin;
        if (i_fire && (i_kind == KIND_TICK)) begin
            n_since_frame = (r_since_frame == COUNT_MAX) ? COUNT_MAX : r_since_frame + 1'b1;
            n_since_slot  = (r_since_slot  == COUNT_MAX) ? COUNT_MAX : r_since_slot  + 1'b1;
            n_since_pulse = (r_since_pulse == COUNT_MAX) ? COUNT_MAX : r_since_pulse + 1'b1;
            if (n_since_frame >= i_cfg.frame_length) begin
                n_since_frame = '0;
                n_running     = 1'b1;
            end
            if (w_frame_done) begin
                n_running      = 1'b0;
                n_slot_counter = '0;
                n_pulse_wanted = 1'b1;
            end
            if (n_running) begin
                if (r_slot_begin) begin
                    n_pulse_wanted = 1'b1;
                    n_slot_begin   = 1'b0;
                    n_since_slot   = '0;
                end else if (n_since_slot >= w_cur_width) begin
                    n_slot_counter = w_slot_sel + 1'b1;
                    n_slot_begin   = 1'b1;
                end
            end
            if (n_pulse_wanted) begin
                if (r_pulse_idle) begin
                    n_pin         = i_cfg.active_level;
                    n_pulse_idle  = 1'b0;
                    n_since_pulse = '0;
                end else if (n_since_pulse >= i_cfg.pulse_length) begin
                    n_pin          = ~i_cfg.active_level;
                    n_pulse_wanted = 1'b0;
                    n_pulse_idle   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since_frame  <= '0;
            r_since_slot   <= '0;
            r_since_pulse  <= '0;
            r_running      <= 1'b0;
            r_pulse_wanted <= 1'b0;
            r_pulse_idle   <= 1'b1;
            r_slot_begin   <= 1'b1;
            r_slot_counter <= '0;
            r_pin          <= ~ACTIVE_RST;
        end else begin
            r_since_frame  <= n_since_frame;
            r_since_slot   <= n_since_slot;
            r_since_pulse  <= n_since_pulse;
            r_running      <= n_running;
            r_pulse_wanted <= n_pulse_wanted;
            r_pulse_idle   <= n_pulse_idle;
            r_slot_begin   <= n_slot_begin;
            r_slot_counter <= n_slot_counter;
            r_pin          <= n_pin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_widths[i] <= (i == 0) ? FIRST_SLOT_RST : OTHER_SLOT_RST;
            end
        end else if (w_wr_ok) begin
            r_widths[i_channel[CH_IDX_W-1:0]] <= i_slot_width;
        end
    end

    assign o_result.pin_level     = n_pin;
    assign o_result.frame_running = n_running;
    assign o_result.slot_index    = n_slot_counter;

`ifndef SYNTHESIS
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_counter <= SLOT_W'(CHANNELS))
        else $error("slot counter beyond the channel count");

    a_pulse_busy_wanted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pulse_idle |-> r_pulse_wanted)
        else $error("pulse in progress without a pending pulse");

    a_write_keeps_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_kind == KIND_WRITE) |=> $stable(r_since_frame) && $stable(r_pin))
        else $error("slot width write changed the timing state");
`endif

endmodule

### hdl/rc_ppm_frame_generator_top.sv
// Top level of the RC PPM frame generator: stream ports, input and result registers.
// Depends on rcppm_pkg, rcppm_apb_regs and rcppm_core.
//
// Usage: each request on the slave stream is either a one-microsecond tick
// (tuser = 0) or a write of one channel's slot width (tuser = 1). Every request
// yields exactly one result on the master stream with the pin level, the
// frame-running flag and the slot index after that request is applied.
// Writes to channels at or beyond the channel count leave the widths unchanged.
// An accepted request is registered in the input register, applied by the
// timing core once the result register can take a result, and its result is
// registered in the result register that drives the master stream.
// One request is taken every cycle while the receiver does not stall; the
// compare and update of the timing core is the rate limit.
// When the receiver stalls, the pending result holds in the result register,
// one more request waits in the input register, and then s_axis_tready drops.
// The APB port sets frame length, pulse length and active level; pready is
// always high. A synchronous reset restores the default widths and settings,
// clears the counters, drives the pin to its idle level and empties both
// registers.
module rc_ppm_frame_generator_top
    import rcppm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // channel[3:0], slot_width[19:4], zero pad
    input  logic                  s_axis_tuser,  // kind[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // pin_level[0], frame_running[1],
                                                 // slot_index[5:2], zero pad
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg              w_cfg;
    t_result           w_result;
    logic              r_in_valid;
    logic              r_in_kind;
    logic [SLOT_W-1:0] r_in_channel;
    logic [CNT_W-1:0]  r_in_width;
    logic              r_out_valid;
    t_result           r_out;
    logic              w_advance;
    logic              w_fire;
    logic              w_accept;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    rcppm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rcppm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_fire       (w_fire),
        .i_kind       (r_in_kind),
        .i_channel    (r_in_channel),
        .i_slot_width (r_in_width),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind    <= s_axis_tuser;
            r_in_channel <= s_axis_tdata[3:0];
            r_in_width   <= s_axis_tdata[19:4];
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.slot_index, r_out.frame_running, r_out.pin_level};

`ifndef SYNTHESIS
    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("input request dropped while the result register was full");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed request produced no result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("registers not empty after reset");
`endif

endmodule
